/* rtl/bstins_pkg.sv */
// shared types and constants for the binary search tree insert block
package bstins_pkg;

  localparam int KEY_W = 32;

  typedef logic [1:0] status_t;

  localparam status_t STAT_INSERTED = 2'd0;
  localparam status_t STAT_DUP      = 2'd1;
  localparam status_t STAT_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DECIDE,
    S_LINK,
    S_FIN
  } state_t;

endpackage

/* rtl/bstins_node_mem.sv */
// node store: one write port, one read port with registered read data
module bstins_node_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 50
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/array_bst_key_insert_core.sv */
// binary search tree insert over a fixed node store, top level
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid, in_ready, key                  | in
//   out     | out_valid, out_ready, status, new_index, | out
//           | entry_count                              |
//
// an insert writes the new node and then links it to its parent; a duplicate
// or full item writes nothing; the walk visits one node per cycle through the
// single read port of the node store, at most entry_count nodes.
// reset empties the tree at once: count 0, root nil; the store is not cleared.
// a new beat is taken only when the previous one has left the walk; a stalled
// output holds its beat while the next key is already walking.
module array_bst_key_insert_core #(
  parameter int CAPACITY = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bstins_pkg::KEY_W-1:0]   key,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bstins_pkg::status_t                   status,
  output logic [$clog2(CAPACITY+1)-1:0]         new_index,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KW = bstins_pkg::KEY_W;
  localparam int EW = KW + 2 * IW;
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  bstins_pkg::state_t state, state_next;

  logic [IW-1:0]        count;
  logic [IW-1:0]        root;
  logic [IW-1:0]        curr;
  logic [IW-1:0]        parent;
  logic [IW-1:0]        steps;
  logic [EW-1:0]        parent_ent;
  logic                 go_left;
  logic                 dup;
  logic signed [KW-1:0] key_r;
  bstins_pkg::status_t  res_status;
  logic [IW-1:0]        res_index;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  logic signed [KW-1:0] ent_key;
  logic [IW-1:0]        node_left;
  logic [IW-1:0]        node_right;
  logic [IW-1:0]        child;
  logic [IW-1:0]        steps_inc;
  logic                 cmp_lt;
  logic                 cmp_eq;
  logic                 walk_more;
  logic                 out_load;

  assign ent_key    = $signed(rd_data[EW-1 -: KW]);
  assign node_left  = rd_data[2*IW-1 : IW];
  assign node_right = rd_data[IW-1 : 0];
  assign cmp_lt     = key_r < ent_key;
  assign cmp_eq     = key_r == ent_key;
  assign child      = cmp_lt ? node_left : node_right;
  assign steps_inc  = steps + 1'b1;
  assign walk_more  = (child < count) && (steps_inc < count);

  bstins_node_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (EW)
  ) u_node_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bstins_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = curr[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = {key_r, NIL, NIL};
    out_load   = 1'b0;
    unique case (state)
      bstins_pkg::S_IDLE: begin
        in_ready = !rst;
        rd_addr  = root[AW-1:0];
        if (in_valid) begin
          rd_en      = 1'b1;
          state_next = (root < count) ? bstins_pkg::S_WALK : bstins_pkg::S_DECIDE;
        end
      end
      bstins_pkg::S_WALK: begin
        rd_addr = child[AW-1:0];
        if (cmp_eq) begin
          state_next = bstins_pkg::S_DECIDE;
        end else if (walk_more) begin
          rd_en = 1'b1;
        end else begin
          state_next = bstins_pkg::S_DECIDE;
        end
      end
      bstins_pkg::S_DECIDE: begin
        if (dup || count >= NIL) begin
          state_next = bstins_pkg::S_FIN;
        end else begin
          wr_en      = 1'b1;
          state_next = bstins_pkg::S_LINK;
        end
      end
      bstins_pkg::S_LINK: begin
        wr_addr = parent[AW-1:0];
        if (go_left) begin
          wr_data = {parent_ent[EW-1 -: KW], count, parent_ent[IW-1:0]};
        end else begin
          wr_data = {parent_ent[EW-1 -: KW], parent_ent[2*IW-1 : IW], count};
        end
        wr_en      = parent < count;
        state_next = bstins_pkg::S_FIN;
      end
      bstins_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = bstins_pkg::S_IDLE;
        end
      end
      default: state_next = bstins_pkg::S_IDLE;
    endcase
  end

  // walk datapath and result registers
  always_ff @(posedge clk) begin
    if (state == bstins_pkg::S_IDLE && in_valid) begin
      key_r  <= key;
      curr   <= root;
      parent <= NIL;
      dup    <= 1'b0;
      steps  <= '0;
    end
    if (state == bstins_pkg::S_WALK) begin
      steps <= steps_inc;
      if (cmp_eq) begin
        dup <= 1'b1;
      end else begin
        parent     <= curr;
        parent_ent <= rd_data;
        go_left    <= cmp_lt;
        curr       <= child;
      end
    end
    if (state == bstins_pkg::S_DECIDE) begin
      priority if (dup) begin
        res_status <= bstins_pkg::STAT_DUP;
        res_index  <= NIL;
      end else if (count >= NIL) begin
        res_status <= bstins_pkg::STAT_FULL;
        res_index  <= NIL;
      end else begin
        res_status <= bstins_pkg::STAT_INSERTED;
        res_index  <= count;
      end
    end
  end

  // tree bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      root  <= NIL;
    end else if (state == bstins_pkg::S_LINK) begin
      count <= count + 1'b1;
      if (!(parent < count)) begin
        root <= count;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      new_index   <= res_index;
      entry_count <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NIL)
    else $error("entry count above capacity");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    state == bstins_pkg::S_WALK |-> !wr_en)
    else $error("node store written during walk");

  a_insert_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bstins_pkg::STAT_INSERTED |-> new_index + 1'b1 == entry_count)
    else $error("inserted index does not match count");

  a_nil_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bstins_pkg::STAT_INSERTED |-> new_index == NIL)
    else $error("non-insert beat carries a node index");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> $past(state) == bstins_pkg::S_LINK)
    else $error("count changed outside link step");

endmodule

/* tb/array_bst_key_insert_core_tb.sv */
// self-checking testbench for the binary search tree insert core
module array_bst_key_insert_core_tb;

  localparam int KEY_W = bstins_pkg::KEY_W;
  localparam int CAP = 256;
  localparam int IDX_W = $clog2(CAP + 1);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 185;

  typedef logic [IDX_W-1:0] node_idx_t;

  typedef struct packed {
    bstins_pkg::status_t status;
    node_idx_t           new_index;
    node_idx_t           entry_count;
  } insert_outcome_t;

  typedef struct {
    logic signed [KEY_W-1:0] key_in;
    insert_outcome_t         outcome;
  } outcome_entry_t;

  typedef struct {
    logic signed [KEY_W-1:0] value;
    bit                      wait_drain;
  } key_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [KEY_W-1:0] key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bstins_pkg::status_t status;
  node_idx_t new_index;
  node_idx_t entry_count;

  array_bst_key_insert_core #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .key(key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .new_index(new_index),
    .entry_count(entry_count)
  );

  // shadow copy of the tree
  logic signed [KEY_W-1:0] tree_key [CAP];
  node_idx_t tree_left [CAP];
  node_idx_t tree_right [CAP];
  int unsigned tree_count = 0;
  int unsigned tree_root = CAP;
  int unsigned deepest_walk = 0;

  key_beat_t pending_keys[$];
  outcome_entry_t insert_outcomes[$];
  logic signed [KEY_W-1:0] drawn_keys[$];

  int unsigned keys_offered = 0;
  int unsigned keys_taken = 0;
  int unsigned results_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned inserted_seen = 0;
  int unsigned dup_seen = 0;
  int unsigned full_seen = 0;
  bit stuck = 1'b0;

  int unsigned run_left = 0;
  bit run_up = 1'b0;
  logic signed [KEY_W-1:0] run_next = '0;

  function automatic insert_outcome_t tree_insert(input logic signed [KEY_W-1:0] k);
    insert_outcome_t res;
    int unsigned cur;
    int unsigned parent;
    int unsigned steps;
    bit to_left;
    bit found;
    cur = tree_root;
    parent = CAP;
    steps = 0;
    to_left = 1'b0;
    found = 1'b0;
    res.new_index = node_idx_t'(CAP);
    while (cur < tree_count && steps < tree_count && !found) begin
      parent = cur;
      steps++;
      if (k < tree_key[cur]) begin
        to_left = 1'b1;
        cur = tree_left[cur];
      end else if (k > tree_key[cur]) begin
        to_left = 1'b0;
        cur = tree_right[cur];
      end else begin
        found = 1'b1;
      end
    end
    if (steps > deepest_walk) deepest_walk = steps;
    if (found) begin
      res.status = bstins_pkg::STAT_DUP;
    end else if (tree_count >= CAP) begin
      res.status = bstins_pkg::STAT_FULL;
    end else begin
      res.status = bstins_pkg::STAT_INSERTED;
      res.new_index = node_idx_t'(tree_count);
      tree_key[tree_count] = k;
      tree_left[tree_count] = node_idx_t'(CAP);
      tree_right[tree_count] = node_idx_t'(CAP);
      if (parent < tree_count) begin
        if (to_left) tree_left[parent] = node_idx_t'(tree_count);
        else tree_right[parent] = node_idx_t'(tree_count);
      end else begin
        tree_root = tree_count;
      end
      tree_count++;
    end
    res.entry_count = node_idx_t'(tree_count);
    return res;
  endfunction

  task automatic add_key(input logic signed [KEY_W-1:0] k, input bit hold);
    key_beat_t b;
    b.value = k;
    b.wait_drain = hold;
    pending_keys.push_back(b);
    drawn_keys.push_back(k);
  endtask

  // mix of fresh keys, near neighbors, repeats and monotonic runs
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned roll;
    logic signed [KEY_W-1:0] k;
    roll = $urandom_range(99);
    if (drawn_keys.size() == 0 || roll < 25) begin
      k = $urandom;
    end else if (roll < 35) begin
      k = drawn_keys[$urandom_range(drawn_keys.size() - 1)];
      k = $urandom_range(1) ? k + 1 : k - 1;
    end else if (roll < 85) begin
      k = drawn_keys[$urandom_range(drawn_keys.size() - 1)];
    end else begin
      if (run_left == 0) begin
        run_next = $urandom;
        run_up = 1'($urandom_range(1));
        run_left = $urandom_range(40, 8);
      end
      k = run_next;
      run_next = run_up ? run_next + 1 : run_next - 1;
      run_left--;
    end
    return k;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && keys_taken < keys_offered) begin
      in_valid <= 1'b1;
    end else if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                 (!pending_keys[0].wait_drain || results_seen == keys_taken)) begin
      in_valid <= 1'b1;
      key <= pending_keys[0].value;
      pending_keys.pop_front();
      keys_offered <= keys_offered + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    outcome_entry_t want;
    bit in_fire;
    bit out_fire;
    if (!rst) begin
      in_fire = in_valid && in_ready;
      out_fire = out_valid && out_ready;
      if (in_fire) begin
        want.key_in = key;
        want.outcome = tree_insert(key);
        insert_outcomes.push_back(want);
        keys_taken <= keys_taken + 1;
      end
      if (out_fire) begin
        results_seen <= results_seen + 1;
        if (insert_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: status %0d new_index %0d entry_count %0d",
                     status, new_index, entry_count);
        end else begin
          want = insert_outcomes.pop_front();
          case (want.outcome.status)
            bstins_pkg::STAT_INSERTED: inserted_seen++;
            bstins_pkg::STAT_DUP: dup_seen++;
            default: full_seen++;
          endcase
          if (status !== want.outcome.status || new_index !== want.outcome.new_index ||
              entry_count !== want.outcome.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("key %0d: expected %0d %0d %0d, got %0d %0d %0d",
                       want.key_in, want.outcome.status, want.outcome.new_index,
                       want.outcome.entry_count, status, new_index, entry_count);
          end
        end
      end
      if (in_fire || out_fire) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= WATCHDOG_LIMIT) stuck <= 1'b1;
      end
    end
  end

  initial begin
    wait (stuck);
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("** array_bst_key_insert_core: FAILED **");
    $finish;
  end

  initial begin
    int unsigned idle_mix [4];
    int unsigned stall_mix [4];
    idle_mix = '{0, 74, 0, 19};
    stall_mix = '{0, 0, 74, 19};

    // empty tree, extremes, repeats and a short descending chain
    add_key(32'sd0, 1'b0);
    add_key(32'sh80000000, 1'b0);
    add_key(32'sh7fffffff, 1'b0);
    add_key(-32'sd1, 1'b0);
    add_key(32'sd1, 1'b0);
    add_key(32'sd0, 1'b0);
    add_key(32'sh80000000, 1'b0);
    add_key(32'sh7fffffff, 1'b0);
    add_key(32'sh7ffffffe, 1'b0);
    add_key(32'sh80000001, 1'b0);
    add_key(32'sh55555555, 1'b0);
    add_key(32'shaaaaaaaa, 1'b0);
    add_key(32'sd100, 1'b0);
    add_key(32'sd99, 1'b0);
    add_key(32'sd98, 1'b0);
    add_key(32'sd99, 1'b0);
    add_key(-32'sd1, 1'b0);
    add_key(32'sh55555555, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      send_idle_pct = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      for (int i = 0; i < PHASE_ITEMS; i++)
        add_key(pick_key(), i == 0 || $urandom_range(99) < 2);
      @(posedge clk);
      while (pending_keys.size() != 0 || keys_offered != keys_taken ||
             results_seen != keys_taken)
        @(posedge clk);
    end

    repeat (300) @(negedge clk);
    if (insert_outcomes.size() != 0) begin
      $display("%0d expected beats never arrived", insert_outcomes.size());
      mismatches += insert_outcomes.size();
    end
    $display("%0d keys over four pacing phases: %0d inserted, %0d duplicates, %0d refused full",
             keys_taken, inserted_seen, dup_seen, full_seen);
    $display("longest search path %0d nodes, %0d mismatches", deepest_walk, mismatches);
    if (mismatches == 0) begin
      $display("** array_bst_key_insert_core: PASSED **");
    end else begin
      $display("** array_bst_key_insert_core: FAILED **");
    end
    $finish;
  end

endmodule
